>>> hw/rtl/pri_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pri_pkg
// Shared types, register codes and constants of the point rotate and
// isometric projection block.
// ----------------------------------------------------------------------------
package pri_pkg;

    // Default module parameters
    localparam int TRIG_FRAC_BITS_DEF = 14;
    localparam int GRID_BITS_DEF      = 10;

    // Fixed field widths
    localparam int COORD_W   = 10;   // point_x, point_y
    localparam int HEIGHT_W  = 13;   // point_z
    localparam int SCREEN_W  = 23;   // screen_x, screen_y
    localparam int CFG_W     = 16;   // widest register
    localparam int CFG_IDX_W = 3;
    localparam int ZOOM_W    = 8;
    localparam int HSCALE_W  = 9;
    localparam int TRIG_W    = 16;
    localparam int OFFSET_W  = 12;
    localparam int EXTENT_W  = 16;
    localparam int SCALED_XY_W = 18; // 10 x 8 unsigned product
    localparam int SCALED_W    = 22; // signed operand width into the rotation
    localparam int PROD_W      = SCALED_W + TRIG_W;

    localparam int EXTENT_LIMIT = 200;
    localparam int SCREEN_MAX   = 4194303;
    localparam int SCREEN_MIN   = -4194304;

    // Register reset values
    localparam logic [ZOOM_W-1:0]          ZOOM_RST    = 8'd20;
    localparam logic signed [HSCALE_W-1:0] HSCALE_RST  = 9'sd1;
    localparam logic signed [TRIG_W-1:0]   SINE_RST    = 16'sd0;
    localparam logic signed [TRIG_W-1:0]   COSINE_RST  = 16'sd16384;
    localparam logic [OFFSET_W-1:0]        XOFF_RST    = 12'd640;
    localparam logic [OFFSET_W-1:0]        YOFF_RST    = 12'd216;
    localparam logic [EXTENT_W-1:0]        EXTENT_RST  = 16'd0;

    // Rotation axis codes
    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } axis_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZOOM         = 3'd0,
        REG_HEIGHT_SCALE = 3'd1,
        REG_AXIS_MODE    = 3'd2,
        REG_SINE         = 3'd3,
        REG_COSINE       = 3'd4,
        REG_X_OFFSET     = 3'd5,
        REG_Y_OFFSET     = 3'd6,
        REG_MAP_EXTENT   = 3'd7
    } reg_idx_t;

    // Load enables of the two rotation stages
    typedef struct packed {
        logic en_mult;
        logic en_sum;
    } rot_ctrl_t;

    // Width of a rotated coordinate with frac fraction bits
    function automatic int rot_width(input int frac);
        int w;
        begin
            w = SCALED_W + frac;
            rot_width = (w > PROD_W + 1) ? w : PROD_W + 1;
        end
    endfunction

endpackage

>>> hw/rtl/point_rotate_isometric_project_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_rotate_isometric_project_core
// Scales one map point, rotates it about the selected axis and projects it
// isometrically to saturated screen coordinates; grid position passes through.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the output is not stalled;
// five register stages (scale, trig multiply, rotate sum, projection sum,
// round and saturate). Each stage has its own valid bit and loads when
// empty or draining, so bubbles fill while the output is stalled.
// Reset: asynchronous, clears all valid bits and loads register defaults.
module point_rotate_isometric_project_core #(
    parameter int TRIG_FRAC_BITS = pri_pkg::TRIG_FRAC_BITS_DEF,
    parameter int GRID_BITS      = pri_pkg::GRID_BITS_DEF,
    parameter int IN_W  = ((2*GRID_BITS + 2*pri_pkg::COORD_W + pri_pkg::HEIGHT_W + 7) / 8) * 8,
    parameter int OUT_W = ((2*GRID_BITS + 2*pri_pkg::SCREEN_W + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [pri_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pri_pkg::CFG_W-1:0]     cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // fields low to high: row_index, column_index, point_x, point_y, point_z
    input  logic [IN_W-1:0]               s_axis_tdata,
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // fields low to high: out_row, out_column, screen_x, screen_y
    output logic [OUT_W-1:0]              m_axis_tdata
);

    localparam int CW    = pri_pkg::COORD_W;
    localparam int HW    = pri_pkg::HEIGHT_W;
    localparam int SW    = pri_pkg::SCALED_W;
    localparam int XYW   = pri_pkg::SCALED_XY_W;
    localparam int SCRW  = pri_pkg::SCREEN_W;
    localparam int ROT_W = pri_pkg::rot_width(TRIG_FRAC_BITS);
    localparam int NW    = ROT_W + 3;
    localparam int STAGES = 5;
    localparam int PAD_W  = OUT_W - 2*GRID_BITS - 2*SCRW;

    localparam logic signed [NW-1:0] BIAS_X = NW'((1 << TRIG_FRAC_BITS) - 1);
    localparam logic signed [NW-1:0] BIAS_Y = NW'((1 << (TRIG_FRAC_BITS + 1)) - 1);
    localparam logic signed [NW-1:0] SAT_HI = NW'(pri_pkg::SCREEN_MAX);
    localparam logic signed [NW-1:0] SAT_LO = NW'(pri_pkg::SCREEN_MIN);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [pri_pkg::ZOOM_W-1:0]            zoom_reg;
    logic signed [pri_pkg::HSCALE_W-1:0]   height_scale_reg;
    pri_pkg::axis_t                        axis_mode_reg;
    logic signed [pri_pkg::TRIG_W-1:0]     sine_reg;
    logic signed [pri_pkg::TRIG_W-1:0]     cosine_reg;
    logic [pri_pkg::OFFSET_W-1:0]          x_offset_reg;
    logic [pri_pkg::OFFSET_W-1:0]          y_offset_reg;
    logic [pri_pkg::EXTENT_W-1:0]          map_extent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg         <= pri_pkg::ZOOM_RST;
            height_scale_reg <= pri_pkg::HSCALE_RST;
            axis_mode_reg    <= pri_pkg::AXIS_Z;
            sine_reg         <= pri_pkg::SINE_RST;
            cosine_reg       <= pri_pkg::COSINE_RST;
            x_offset_reg     <= pri_pkg::XOFF_RST;
            y_offset_reg     <= pri_pkg::YOFF_RST;
            map_extent_reg   <= pri_pkg::EXTENT_RST;
        end
        else if (cfg_we)
        begin
            unique case (pri_pkg::reg_idx_t'(cfg_index))
                pri_pkg::REG_ZOOM:         zoom_reg <= cfg_data[pri_pkg::ZOOM_W-1:0];
                pri_pkg::REG_HEIGHT_SCALE:
                    height_scale_reg <= $signed(cfg_data[pri_pkg::HSCALE_W-1:0]);
                pri_pkg::REG_AXIS_MODE:    axis_mode_reg <= pri_pkg::axis_t'(cfg_data[1:0]);
                pri_pkg::REG_SINE:         sine_reg <= $signed(cfg_data);
                pri_pkg::REG_COSINE:       cosine_reg <= $signed(cfg_data);
                pri_pkg::REG_X_OFFSET:     x_offset_reg <= cfg_data[pri_pkg::OFFSET_W-1:0];
                pri_pkg::REG_Y_OFFSET:     y_offset_reg <= cfg_data[pri_pkg::OFFSET_W-1:0];
                pri_pkg::REG_MAP_EXTENT:   map_extent_reg <= cfg_data;
                default:                   zoom_reg <= zoom_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Stage valids and load enables
    // ------------------------------------------------------------------------
    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   en;

    always_comb
    begin
        en[STAGES] = m_axis_tready;
        for (int k = STAGES - 1; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = valid_reg[STAGES-1];

    // ------------------------------------------------------------------------
    // Input unpack
    // ------------------------------------------------------------------------
    logic [GRID_BITS-1:0]  in_row, in_col;
    logic [CW-1:0]         in_px, in_py;
    logic signed [HW-1:0]  in_pz;

    assign in_row = s_axis_tdata[GRID_BITS-1:0];
    assign in_col = s_axis_tdata[2*GRID_BITS-1:GRID_BITS];
    assign in_px  = s_axis_tdata[2*GRID_BITS+CW-1:2*GRID_BITS];
    assign in_py  = s_axis_tdata[2*GRID_BITS+2*CW-1:2*GRID_BITS+CW];
    assign in_pz  = $signed(s_axis_tdata[2*GRID_BITS+2*CW+HW-1:2*GRID_BITS+2*CW]);

    // Grid position carried alongside the data
    logic [GRID_BITS-1:0] row_reg [STAGES];
    logic [GRID_BITS-1:0] col_reg [STAGES];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            row_reg[0] <= in_row;
            col_reg[0] <= in_col;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (en[k])
            begin
                row_reg[k] <= row_reg[k-1];
                col_reg[k] <= col_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 1: zoom and height scale
    // ------------------------------------------------------------------------
    logic [pri_pkg::ZOOM_W-1:0] zoom_eff;
    logic [XYW-1:0]             x0_next, y0_next, x0_reg, y0_reg;
    logic signed [SW-1:0]       h0_next, h0_reg;

    always_comb
    begin
        zoom_eff = (map_extent_reg > pri_pkg::EXTENT_W'(pri_pkg::EXTENT_LIMIT))
                   ? pri_pkg::ZOOM_W'(1) : zoom_reg;
        x0_next  = XYW'(in_px) * XYW'(zoom_eff);
        y0_next  = XYW'(in_py) * XYW'(zoom_eff);
        h0_next  = SW'(in_pz) * SW'(height_scale_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x0_reg <= x0_next;
            y0_reg <= y0_next;
            h0_reg <= h0_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stages 2 and 3: rotation
    // ------------------------------------------------------------------------
    pri_pkg::rot_ctrl_t       rot_ctrl;
    logic signed [ROT_W-1:0]  rx, ry, rz;

    assign rot_ctrl.en_mult = en[1];
    assign rot_ctrl.en_sum  = en[2];

    pri_rotate #(
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .ROT_W          (ROT_W)
    ) u_rotate (
        .clk    (clk),
        .ctrl   (rot_ctrl),
        .axis   (axis_mode_reg),
        .sine   (sine_reg),
        .cosine (cosine_reg),
        .x0     ($signed(SW'(x0_reg))),
        .y0     ($signed(SW'(y0_reg))),
        .h0     (h0_reg),
        .rx     (rx),
        .ry     (ry),
        .rz     (rz)
    );

    // ------------------------------------------------------------------------
    // Stage 4: isometric projection sums (fixed point)
    // ------------------------------------------------------------------------
    logic signed [NW-1:0] rx_e, ry_e, rz_e, xoff_e, yoff_e;
    logic signed [NW-1:0] nx_next, ny_next, nx_reg, ny_reg;

    always_comb
    begin
        rx_e    = NW'(rx);
        ry_e    = NW'(ry);
        rz_e    = NW'(rz);
        xoff_e  = $signed(NW'(x_offset_reg)) <<< TRIG_FRAC_BITS;
        yoff_e  = $signed(NW'(y_offset_reg)) <<< (TRIG_FRAC_BITS + 1);
        nx_next = rx_e - ry_e + xoff_e;
        ny_next = yoff_e - (rz_e <<< 1) - rx_e - ry_e;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            nx_reg <= nx_next;
            ny_reg <= ny_next;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 5: truncate toward zero and saturate
    // ------------------------------------------------------------------------
    logic signed [NW-1:0]   qx, qy;
    logic signed [SCRW-1:0] sx_next, sy_next, sx_reg, sy_reg;

    always_comb
    begin
        // negative sums get a bias so the arithmetic shift rounds toward zero
        qx = $signed(nx_reg + (nx_reg[NW-1] ? BIAS_X : '0)) >>> TRIG_FRAC_BITS;
        qy = $signed(ny_reg + (ny_reg[NW-1] ? BIAS_Y : '0)) >>> (TRIG_FRAC_BITS + 1);
        priority if (qx > SAT_HI)
            sx_next = SCRW'(SAT_HI);
        else if (qx < SAT_LO)
            sx_next = SCRW'(SAT_LO);
        else
            sx_next = qx[SCRW-1:0];
        priority if (qy > SAT_HI)
            sy_next = SCRW'(SAT_HI);
        else if (qy < SAT_LO)
            sy_next = SCRW'(SAT_LO);
        else
            sy_next = qy[SCRW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
    end

    // Output pack
    generate
        if (PAD_W > 0)
        begin : g_pad
            assign m_axis_tdata = {PAD_W'(0), sy_reg, sx_reg,
                                   col_reg[STAGES-1], row_reg[STAGES-1]};
        end
        else
        begin : g_nopad
            assign m_axis_tdata = {sy_reg, sx_reg, col_reg[STAGES-1], row_reg[STAGES-1]};
        end
    endgenerate

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    // an accepted transaction lands in the first stage
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> valid_reg[0])
        else $error("accepted transaction not captured in stage 1");

    // an empty output stage never back-pressures the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // a stalled inner stage keeps its item
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] && !en[1] |=> valid_reg[0])
        else $error("stage 1 item lost during stall");

endmodule

>>> hw/rtl/pri_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pri_rotate
// Two pipeline stages of the axis rotation: four registered trig products,
// then the butterfly sums routed to rx, ry, rz by the selected axis.
// ----------------------------------------------------------------------------
module pri_rotate #(
    parameter int TRIG_FRAC_BITS = pri_pkg::TRIG_FRAC_BITS_DEF,
    parameter int ROT_W          = pri_pkg::rot_width(TRIG_FRAC_BITS)
) (
    input  logic                                clk,
    input  pri_pkg::rot_ctrl_t                  ctrl,
    input  pri_pkg::axis_t                      axis,
    input  logic signed [pri_pkg::TRIG_W-1:0]   sine,
    input  logic signed [pri_pkg::TRIG_W-1:0]   cosine,
    input  logic signed [pri_pkg::SCALED_W-1:0] x0,
    input  logic signed [pri_pkg::SCALED_W-1:0] y0,
    input  logic signed [pri_pkg::SCALED_W-1:0] h0,
    output logic signed [ROT_W-1:0]             rx,
    output logic signed [ROT_W-1:0]             ry,
    output logic signed [ROT_W-1:0]             rz
);

    localparam int SW = pri_pkg::SCALED_W;
    localparam int PW = pri_pkg::PROD_W;

    logic signed [SW-1:0] u_op;
    logic signed [SW-1:0] v_op;

    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [PW-1:0] p0_next, p1_next, p2_next, p3_next;
    logic signed [SW-1:0] x_reg, y_reg, h_reg;

    logic signed [PW:0]      u_rot, v_rot;
    logic signed [ROT_W-1:0] u_ext, v_ext, x_sh, y_sh, h_sh;
    logic signed [ROT_W-1:0] rx_reg, ry_reg, rz_reg;
    logic signed [ROT_W-1:0] rx_next, ry_next, rz_next;

    // Operand pair (u, v): u' = u*c - v*s, v' = u*s + v*c
    always_comb
    begin
        unique case (axis)
            pri_pkg::AXIS_X:
            begin
                u_op = y0;
                v_op = h0;
            end
            pri_pkg::AXIS_Y:
            begin
                u_op = h0;
                v_op = x0;
            end
            default:
            begin
                u_op = x0;
                v_op = y0;
            end
        endcase
    end

    // Stage A: trig products
    always_comb
    begin
        p0_next = PW'(u_op) * PW'(cosine);
        p1_next = PW'(v_op) * PW'(sine);
        p2_next = PW'(u_op) * PW'(sine);
        p3_next = PW'(v_op) * PW'(cosine);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_mult)
        begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            p3_reg <= p3_next;
            x_reg  <= x0;
            y_reg  <= y0;
            h_reg  <= h0;
        end
    end

    // Stage B: butterfly sums and axis routing
    always_comb
    begin
        u_rot = (PW+1)'(p0_reg) - (PW+1)'(p1_reg);
        v_rot = (PW+1)'(p2_reg) + (PW+1)'(p3_reg);
        u_ext = ROT_W'(u_rot);
        v_ext = ROT_W'(v_rot);
        x_sh  = ROT_W'(x_reg) <<< TRIG_FRAC_BITS;
        y_sh  = ROT_W'(y_reg) <<< TRIG_FRAC_BITS;
        h_sh  = ROT_W'(h_reg) <<< TRIG_FRAC_BITS;
        unique case (axis)
            pri_pkg::AXIS_X:
            begin
                rx_next = x_sh;
                ry_next = u_ext;
                rz_next = v_ext;
            end
            pri_pkg::AXIS_Y:
            begin
                rx_next = v_ext;
                ry_next = y_sh;
                rz_next = u_ext;
            end
            pri_pkg::AXIS_Z:
            begin
                rx_next = u_ext;
                ry_next = v_ext;
                rz_next = h_sh;
            end
            default:
            begin
                rx_next = x_sh;
                ry_next = y_sh;
                rz_next = h_sh;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_sum)
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
            rz_reg <= rz_next;
        end
    end

    assign rx = rx_reg;
    assign ry = ry_reg;
    assign rz = rz_reg;

endmodule

>>> tb/tb_point_rotate_isometric_project_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_rotate_isometric_project_core
// Self-checking bench for the point rotate and isometric projection core.
// Each accepted map point is projected by a behavioral model running on the
// bench's own copy of the registers. Every output transaction is compared
// field by field with the oldest projection waiting. Directed points cover
// the field extremes, every rotation axis including the no-rotation code,
// zero zoom, the large-map zoom override and out-of-range trig values.
// Random phases then reprogram all registers between batches of random
// points, with random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_point_rotate_isometric_project_core;

    localparam int     IN_W           = 56;
    localparam int     OUT_W          = 72;
    localparam longint TRIG_ONE       = 64'sd16384;    // 1.0 in Q1.14
    localparam int     HOLD_CYCLES    = 300;           // long sink hold-off
    localparam int     SETTLE_CYCLES  = 20;            // > pipeline latency
    // longest quiet span is the sink hold-off; allow many times that
    localparam int     WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [pri_pkg::GRID_BITS_DEF-1:0]   row;
        logic [pri_pkg::GRID_BITS_DEF-1:0]   col;
        logic [pri_pkg::COORD_W-1:0]         px;
        logic [pri_pkg::COORD_W-1:0]         py;
        logic signed [pri_pkg::HEIGHT_W-1:0] pz;
    } map_point_t;

    typedef struct {
        logic [pri_pkg::GRID_BITS_DEF-1:0]   row;
        logic [pri_pkg::GRID_BITS_DEF-1:0]   col;
        logic signed [pri_pkg::SCREEN_W-1:0] sx;
        logic signed [pri_pkg::SCREEN_W-1:0] sy;
    } screen_point_t;

    // DUT signals
    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          cfg_we        = 1'b0;
    logic [pri_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
    logic [pri_pkg::CFG_W-1:0]     cfg_data      = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [IN_W-1:0]               s_axis_tdata  = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [OUT_W-1:0]              m_axis_tdata;

    // Register shadow used by the projection model
    logic [pri_pkg::ZOOM_W-1:0]          zoom_set   = pri_pkg::ZOOM_RST;
    logic signed [pri_pkg::HSCALE_W-1:0] hscale_set = pri_pkg::HSCALE_RST;
    pri_pkg::axis_t                      axis_set   = pri_pkg::AXIS_Z;
    logic signed [pri_pkg::TRIG_W-1:0]   sine_set   = pri_pkg::SINE_RST;
    logic signed [pri_pkg::TRIG_W-1:0]   cosine_set = pri_pkg::COSINE_RST;
    logic [pri_pkg::OFFSET_W-1:0]        xoff_set   = pri_pkg::XOFF_RST;
    logic [pri_pkg::OFFSET_W-1:0]        yoff_set   = pri_pkg::YOFF_RST;
    logic [pri_pkg::EXTENT_W-1:0]        extent_set = pri_pkg::EXTENT_RST;

    // Projections waiting for their output transaction
    screen_point_t projected_q[$];
    int            points_sent  = 0;
    int            results_seen = 0;
    int            n_errors     = 0;

    // Idle control
    bit   gaps_on    = 1'b1;
    logic stalls_on  = 1'b1;
    int   hold_reqs  = 0;
    int   hold_seen  = 0;
    int   hold_left  = 0;
    int   idle_count = 0;

    point_rotate_isometric_project_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Projection model
    // ------------------------------------------------------------------
    function automatic logic signed [pri_pkg::SCREEN_W-1:0] clamp_screen(input longint v);
        if (v > pri_pkg::SCREEN_MAX)
            v = pri_pkg::SCREEN_MAX;
        if (v < pri_pkg::SCREEN_MIN)
            v = pri_pkg::SCREEN_MIN;
        return v[pri_pkg::SCREEN_W-1:0];
    endfunction

    function automatic screen_point_t project_point(input map_point_t p);
        longint        zf, x0, y0, h0, s, c, rx, ry, rz;
        screen_point_t r;
        // large maps ignore the zoom register
        zf = (extent_set > pri_pkg::EXTENT_LIMIT) ? 64'sd1 : longint'(zoom_set);
        x0 = longint'(p.px) * zf;
        y0 = longint'(p.py) * zf;
        h0 = longint'(p.pz) * longint'(hscale_set);
        s  = longint'(sine_set);
        c  = longint'(cosine_set);
        // rotated coordinates keep 14 fraction bits
        case (axis_set)
            pri_pkg::AXIS_X:
            begin
                rx = x0 * TRIG_ONE;
                ry = y0 * c - h0 * s;
                rz = y0 * s + h0 * c;
            end
            pri_pkg::AXIS_Y:
            begin
                rx = h0 * s + x0 * c;
                ry = y0 * TRIG_ONE;
                rz = h0 * c - x0 * s;
            end
            pri_pkg::AXIS_Z:
            begin
                rx = x0 * c - y0 * s;
                ry = x0 * s + y0 * c;
                rz = h0 * TRIG_ONE;
            end
            default:
            begin
                rx = x0 * TRIG_ONE;
                ry = y0 * TRIG_ONE;
                rz = h0 * TRIG_ONE;
            end
        endcase
        // one truncation toward zero at the very end
        r.row = p.row;
        r.col = p.col;
        r.sx  = clamp_screen((rx - ry + longint'(xoff_set) * TRIG_ONE) / TRIG_ONE);
        r.sy  = clamp_screen((-2 * rz - (rx + ry) + 2 * longint'(yoff_set) * TRIG_ONE)
                             / (2 * TRIG_ONE));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sink ready: random stalls, plus a counted hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(99) < 28)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Output check against the oldest projection
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        screen_point_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.row = m_axis_tdata[9:0];
            got.col = m_axis_tdata[19:10];
            got.sx  = m_axis_tdata[42:20];
            got.sy  = m_axis_tdata[65:43];
            results_seen++;
            if (projected_q.size() == 0)
            begin
                $error("unexpected output transaction: row %0d col %0d", got.row, got.col);
                n_errors++;
            end
            else
            begin
                want = projected_q.pop_front();
                if (got.row !== want.row)
                begin
                    $error("out_row: expected %0d, got %0d", want.row, got.row);
                    n_errors++;
                end
                if (got.col !== want.col)
                begin
                    $error("out_column: expected %0d, got %0d", want.col, got.col);
                    n_errors++;
                end
                if (got.sx !== want.sx)
                begin
                    $error("screen_x: expected %0d, got %0d", want.sx, got.sx);
                    n_errors++;
                end
                if (got.sy !== want.sy)
                begin
                    $error("screen_y: expected %0d, got %0d", want.sy, got.sy);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles without any transaction or register write
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready))
            idle_count = 0;
        else
        begin
            idle_count++;
            if (idle_count >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input pri_pkg::reg_idx_t idx,
                             input logic [pri_pkg::CFG_W-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        case (idx)
            pri_pkg::REG_ZOOM:         zoom_set   = v[pri_pkg::ZOOM_W-1:0];
            pri_pkg::REG_HEIGHT_SCALE: hscale_set = v[pri_pkg::HSCALE_W-1:0];
            pri_pkg::REG_AXIS_MODE:    axis_set   = pri_pkg::axis_t'(v[1:0]);
            pri_pkg::REG_SINE:         sine_set   = v;
            pri_pkg::REG_COSINE:       cosine_set = v;
            pri_pkg::REG_X_OFFSET:     xoff_set   = v[pri_pkg::OFFSET_W-1:0];
            pri_pkg::REG_Y_OFFSET:     yoff_set   = v[pri_pkg::OFFSET_W-1:0];
            pri_pkg::REG_MAP_EXTENT:   extent_set = v;
            default:                   ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // offer one point, with an optional gap first; returns on acceptance
    task automatic send_point(input map_point_t p);
        while (gaps_on && $urandom_range(99) < 28)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, p.pz, p.py, p.px, p.col, p.row};
        do
            @(posedge clk);
        while (!s_axis_tready);
        projected_q.push_back(project_point(p));
        points_sent++;
    endtask

    // stop offering and wait until every projection has come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (results_seen < points_sent)
            @(posedge clk);
        @(posedge clk);
    endtask

    function automatic map_point_t build_point(input int row, input int col,
                                               input int x, input int y, input int z);
        map_point_t p;
        p.row = 10'(row);
        p.col = 10'(col);
        p.px  = 10'(x);
        p.py  = 10'(y);
        p.pz  = 13'(z);
        return p;
    endfunction

    function automatic map_point_t random_point();
        map_point_t p;
        p.row = 10'($urandom_range(1023));
        p.col = 10'($urandom_range(1023));
        p.px  = 10'($urandom_range(1023));
        p.py  = 10'($urandom_range(1023));
        p.pz  = 13'($urandom_range(8191));
        // now and then a corner of the input space
        if ($urandom_range(7) == 0)
        begin
            p.px = $urandom_range(1) ? 10'd1023 : 10'd0;
            p.py = $urandom_range(1) ? 10'd1023 : 10'd0;
            p.pz = $urandom_range(1) ? 13'sd4095 : -13'sd4096;
        end
        return p;
    endfunction

    function automatic logic [pri_pkg::CFG_W-1:0] random_trig();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h4000;
            3:       return 16'hC000;
            4:       return 16'h0000;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [pri_pkg::CFG_W-1:0] random_offset();
        case ($urandom_range(3))
            0:       return 16'd0;
            1:       return 16'd4095;
            default: return 16'($urandom_range(4095));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // register defaults after reset
    task automatic test_reset_config();
        send_point(build_point(0, 0, 0, 0, 0));
        send_point(build_point(1023, 1023, 1023, 1023, 4095));
        send_point(build_point(512, 5, 300, 700, -4096));
        wait_for_results();
    endtask

    // every axis code at a 45 degree angle, including no rotation
    task automatic test_axes();
        pri_pkg::axis_t ax;
        write_reg(pri_pkg::REG_ZOOM, 16'd255);
        write_reg(pri_pkg::REG_HEIGHT_SCALE, 16'h0101);     // -255
        write_reg(pri_pkg::REG_SINE, 16'd11585);
        write_reg(pri_pkg::REG_COSINE, 16'd11585);
        write_reg(pri_pkg::REG_X_OFFSET, 16'd2048);
        write_reg(pri_pkg::REG_Y_OFFSET, 16'd1024);
        ax = pri_pkg::AXIS_X;
        repeat (4)
        begin
            write_reg(pri_pkg::REG_AXIS_MODE, 16'(ax));
            send_point(build_point(3, 7, 1023, 17, -4096));
            send_point(build_point(1000, 1, 5, 1023, 4095));
            wait_for_results();
            ax = ax.next();
        end
    endtask

    // zero zoom and the large-map override, with identity rotation
    task automatic test_zoom_extent();
        write_reg(pri_pkg::REG_AXIS_MODE, 16'(pri_pkg::AXIS_Z));
        write_reg(pri_pkg::REG_SINE, 16'd0);
        write_reg(pri_pkg::REG_COSINE, 16'd16384);
        write_reg(pri_pkg::REG_HEIGHT_SCALE, 16'd3);
        write_reg(pri_pkg::REG_ZOOM, 16'd0);
        write_reg(pri_pkg::REG_MAP_EXTENT, 16'd0);
        send_point(build_point(10, 20, 1023, 1023, 100));
        wait_for_results();
        // at the limit the zoom register still applies
        write_reg(pri_pkg::REG_MAP_EXTENT, 16'd200);
        send_point(build_point(11, 21, 1023, 1023, 100));
        wait_for_results();
        // just above it zoom is taken as one
        write_reg(pri_pkg::REG_MAP_EXTENT, 16'd201);
        send_point(build_point(12, 22, 1023, 1023, 100));
        wait_for_results();
        write_reg(pri_pkg::REG_ZOOM, 16'd255);
        write_reg(pri_pkg::REG_MAP_EXTENT, 16'd65535);
        send_point(build_point(13, 23, 1023, 511, -100));
        wait_for_results();
    endtask

    // trig registers beyond +/-1 and the largest magnitudes the fields allow
    task automatic test_trig_extremes();
        write_reg(pri_pkg::REG_MAP_EXTENT, 16'd0);
        write_reg(pri_pkg::REG_ZOOM, 16'd255);
        write_reg(pri_pkg::REG_HEIGHT_SCALE, 16'h0100);     // -256
        write_reg(pri_pkg::REG_AXIS_MODE, 16'(pri_pkg::AXIS_X));
        write_reg(pri_pkg::REG_SINE, 16'h8000);
        write_reg(pri_pkg::REG_COSINE, 16'h7FFF);
        write_reg(pri_pkg::REG_X_OFFSET, 16'd0);
        write_reg(pri_pkg::REG_Y_OFFSET, 16'd4095);
        send_point(build_point(1023, 0, 1023, 1023, -4096));
        wait_for_results();
        write_reg(pri_pkg::REG_AXIS_MODE, 16'(pri_pkg::AXIS_Y));
        send_point(build_point(0, 1023, 1023, 1023, 4095));
        wait_for_results();
        write_reg(pri_pkg::REG_AXIS_MODE, 16'(pri_pkg::AXIS_Z));
        write_reg(pri_pkg::REG_SINE, 16'h7FFF);
        write_reg(pri_pkg::REG_COSINE, 16'h8000);
        write_reg(pri_pkg::REG_X_OFFSET, 16'd4095);
        write_reg(pri_pkg::REG_Y_OFFSET, 16'd0);
        send_point(build_point(0, 1023, 1023, 0, 4095));
        wait_for_results();
    endtask

    // sink holds off long enough for the pipeline to fill and stall the source
    task automatic test_backpressure();
        gaps_on = 1'b0;
        hold_reqs <= hold_reqs + 1;
        repeat (64)
            send_point(random_point());
        wait_for_results();
        gaps_on = 1'b1;
    endtask

    // random register settings, each followed by a batch of random points
    task automatic test_random_phases();
        int phase;
        for (phase = 0; phase < 12; phase++)
        begin
            // one long phase runs with no gaps and no stalls at all
            gaps_on = (phase != 1);
            stalls_on <= (phase != 1);
            case ($urandom_range(5))
                0:       write_reg(pri_pkg::REG_ZOOM, 16'd0);
                1:       write_reg(pri_pkg::REG_ZOOM, 16'd1);
                2:       write_reg(pri_pkg::REG_ZOOM, 16'd255);
                default: write_reg(pri_pkg::REG_ZOOM, 16'($urandom_range(255)));
            endcase
            case ($urandom_range(5))
                0:       write_reg(pri_pkg::REG_HEIGHT_SCALE, 16'h0100);
                1:       write_reg(pri_pkg::REG_HEIGHT_SCALE, 16'd255);
                2:       write_reg(pri_pkg::REG_HEIGHT_SCALE, 16'd0);
                default: write_reg(pri_pkg::REG_HEIGHT_SCALE, 16'($urandom_range(511)));
            endcase
            write_reg(pri_pkg::REG_AXIS_MODE, 16'($urandom_range(3)));
            write_reg(pri_pkg::REG_SINE, random_trig());
            write_reg(pri_pkg::REG_COSINE, random_trig());
            write_reg(pri_pkg::REG_X_OFFSET, random_offset());
            write_reg(pri_pkg::REG_Y_OFFSET, random_offset());
            case ($urandom_range(7))
                0:       write_reg(pri_pkg::REG_MAP_EXTENT, 16'd200);
                1:       write_reg(pri_pkg::REG_MAP_EXTENT, 16'd201);
                2:       write_reg(pri_pkg::REG_MAP_EXTENT, 16'd65535);
                3:       write_reg(pri_pkg::REG_MAP_EXTENT, 16'($urandom_range(65535)));
                default: write_reg(pri_pkg::REG_MAP_EXTENT, 16'($urandom_range(200)));
            endcase
            repeat ((phase == 1) ? 300 : 140)
                send_point(random_point());
            wait_for_results();
        end
        gaps_on = 1'b1;
        stalls_on <= 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_axes();
        test_zoom_extent();
        test_trig_extremes();
        test_backpressure();
        test_random_phases();

        wait_for_results();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (projected_q.size() != 0)
        begin
            $error("%0d projections never came out", projected_q.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
